// File: rtl/core/ppt_pkg.sv
package ppt_pkg;

    // Widths of the parsed values and of the pair counter
    localparam int VALUE_WIDTH = 16;
    localparam int INDEX_WIDTH = 16;
    localparam int FIELD_WIDTH = 16;
    localparam int NUM_FIELDS  = 6;
    localparam int FIELD_IDX_W = 3;
    localparam int DIGIT_W     = 4;

    localparam int VALUE_EXT_W = (VALUE_WIDTH > FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
    localparam int INDEX_EXT_W = (INDEX_WIDTH > FIELD_WIDTH) ? INDEX_WIDTH : FIELD_WIDTH;

    // Characters of the text stream
    localparam logic [7:0] CH_COMMENT = 8'h2D;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;

    // Token kinds passed from the classifier to the executor
    localparam logic [1:0] TK_DIGIT   = 2'd0;
    localparam logic [1:0] TK_SEP     = 2'd1;
    localparam logic [1:0] TK_NEWLINE = 2'd2;
    localparam logic [1:0] TK_CLEAR   = 2'd3;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [INDEX_WIDTH-1:0] t_index;
    typedef logic [FIELD_WIDTH-1:0] t_field;

    typedef struct packed {
        logic [1:0]         kind;
        logic [DIGIT_W-1:0] digit;
    } t_token;

    typedef struct packed {
        t_field first_x;
        t_field first_y;
        t_field first_z;
        t_field second_x;
        t_field second_y;
        t_field second_z;
        t_field pair_number;
    } t_result;

    // Low bits of a value, zero-extended when the value is narrower
    function automatic t_field value_to_field(input t_value v);
        logic [VALUE_EXT_W-1:0] ext;
        ext = VALUE_EXT_W'(v);
        return ext[FIELD_WIDTH-1:0];
    endfunction

    function automatic t_field index_to_field(input t_index v);
        logic [INDEX_EXT_W-1:0] ext;
        ext = INDEX_EXT_W'(v);
        return ext[FIELD_WIDTH-1:0];
    endfunction

endpackage

// File: rtl/core/ppt_front.sv
module ppt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_text_byte,
    output logic           o_tok_valid,
    output ppt_pkg::t_token o_token
);

    logic r_in_comment;
    logic n_in_comment;

    // Classify the byte and track the comment state
    always_comb begin
        n_in_comment      = r_in_comment;
        o_tok_valid       = 1'b0;
        o_token.kind      = ppt_pkg::TK_DIGIT;
        o_token.digit     = ppt_pkg::DIGIT_W'(i_text_byte - ppt_pkg::CH_ZERO);
        if (r_in_comment) begin
            if (i_text_byte == ppt_pkg::CH_NEWLINE) begin
                n_in_comment = 1'b0;
            end
        end else if (i_text_byte == ppt_pkg::CH_COMMENT) begin
            n_in_comment = 1'b1;
            o_tok_valid  = 1'b1;
            o_token.kind = ppt_pkg::TK_CLEAR;
        end else if (i_text_byte == ppt_pkg::CH_NEWLINE) begin
            o_tok_valid  = 1'b1;
            o_token.kind = ppt_pkg::TK_NEWLINE;
        end else if (i_text_byte == ppt_pkg::CH_COLON || i_text_byte == ppt_pkg::CH_SPACE) begin
            o_tok_valid  = 1'b1;
            o_token.kind = ppt_pkg::TK_SEP;
        end else if (i_text_byte inside {[ppt_pkg::CH_ZERO:ppt_pkg::CH_NINE]}) begin
            o_tok_valid  = 1'b1;
            o_token.kind = ppt_pkg::TK_DIGIT;
        end
        if (!i_accept) begin
            o_tok_valid  = 1'b0;
            n_in_comment = r_in_comment;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment <= 1'b0;
        end else begin
            r_in_comment <= n_in_comment;
        end
    end

endmodule

// File: rtl/core/ppt_tok_queue.sv
module ppt_tok_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  ppt_pkg::t_token i_wr_token,
    output logic            o_full,
    input  logic            i_rd_en,
    output logic            o_empty,
    output ppt_pkg::t_token o_rd_token
);

    ppt_pkg::t_token r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full     = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign o_rd_token = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_wr_en && !i_rd_en) begin
            n_count = r_count + 2'd1;
        end else if (!i_wr_en && i_rd_en) begin
            n_count = r_count - 2'd1;
        end
    end

    // Store the incoming token
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wptr] <= i_wr_token;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_wr_en) begin
                r_wptr <= ~r_wptr;
            end
            if (i_rd_en) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/core/ppt_back.sv
module ppt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_empty,
    input  ppt_pkg::t_token  i_token,
    output logic             o_tok_pop,
    input  logic             i_res_pop,
    output logic             o_res_empty,
    output ppt_pkg::t_result o_result
);

    ppt_pkg::t_value r_acc [ppt_pkg::NUM_FIELDS];
    logic [ppt_pkg::FIELD_IDX_W-1:0] r_field_idx;
    ppt_pkg::t_index r_pair_cnt;

    ppt_pkg::t_result r_res_mem [2];
    logic       r_res_wptr;
    logic       r_res_rptr;
    logic [1:0] r_res_count;
    logic [1:0] n_res_count;

    logic res_full;
    logic res_push;
    logic field_open;
    logic [ppt_pkg::VALUE_WIDTH+3:0] acc_mac;
    ppt_pkg::t_value acc_sat;
    ppt_pkg::t_result new_result;

    assign res_full    = (r_res_count == 2'd2);
    assign o_res_empty = (r_res_count == 2'd0);
    assign o_result    = r_res_mem[r_res_rptr];

    // Take a token unless it is a newline and the result queue is full
    assign o_tok_pop = !i_tok_empty && !(i_token.kind == ppt_pkg::TK_NEWLINE && res_full);
    assign res_push  = o_tok_pop && (i_token.kind == ppt_pkg::TK_NEWLINE);

    // Multiply the open field by ten, add the digit, saturate
    assign field_open = (r_field_idx < ppt_pkg::FIELD_IDX_W'(ppt_pkg::NUM_FIELDS));
    always_comb begin
        acc_mac = '0;
        if (field_open) begin
            acc_mac = ((ppt_pkg::VALUE_WIDTH+4)'(r_acc[r_field_idx]) << 3)
                    + ((ppt_pkg::VALUE_WIDTH+4)'(r_acc[r_field_idx]) << 1)
                    + (ppt_pkg::VALUE_WIDTH+4)'(i_token.digit);
        end
        if (acc_mac[ppt_pkg::VALUE_WIDTH+3:ppt_pkg::VALUE_WIDTH] != 4'd0) begin
            acc_sat = '1;
        end else begin
            acc_sat = acc_mac[ppt_pkg::VALUE_WIDTH-1:0];
        end
    end

    always_comb begin
        new_result.first_x     = ppt_pkg::value_to_field(r_acc[0]);
        new_result.first_y     = ppt_pkg::value_to_field(r_acc[1]);
        new_result.first_z     = ppt_pkg::value_to_field(r_acc[2]);
        new_result.second_x    = ppt_pkg::value_to_field(r_acc[3]);
        new_result.second_y    = ppt_pkg::value_to_field(r_acc[4]);
        new_result.second_z    = ppt_pkg::value_to_field(r_acc[5]);
        new_result.pair_number = ppt_pkg::index_to_field(r_pair_cnt);
    end

    // Execute the token on the line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_idx <= '0;
            r_pair_cnt  <= '0;
            for (int k = 0; k < ppt_pkg::NUM_FIELDS; k++) begin
                r_acc[k] <= '0;
            end
        end else if (o_tok_pop) begin
            case (i_token.kind)
                ppt_pkg::TK_DIGIT: begin
                    if (field_open) begin
                        r_acc[r_field_idx] <= acc_sat;
                    end
                end
                ppt_pkg::TK_SEP: begin
                    if (field_open) begin
                        r_field_idx <= r_field_idx + ppt_pkg::FIELD_IDX_W'(1);
                    end
                end
                ppt_pkg::TK_NEWLINE: begin
                    r_pair_cnt  <= r_pair_cnt + ppt_pkg::t_index'(1);
                    r_field_idx <= '0;
                    for (int k = 0; k < ppt_pkg::NUM_FIELDS; k++) begin
                        r_acc[k] <= '0;
                    end
                end
                ppt_pkg::TK_CLEAR: begin
                    r_field_idx <= '0;
                    for (int k = 0; k < ppt_pkg::NUM_FIELDS; k++) begin
                        r_acc[k] <= '0;
                    end
                end
                default: begin
                    r_field_idx <= r_field_idx;
                end
            endcase
        end
    end

    // Hold finished results until popped
    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res_mem[r_res_wptr] <= new_result;
        end
    end

    always_comb begin
        n_res_count = r_res_count;
        if (res_push && !i_res_pop) begin
            n_res_count = r_res_count + 2'd1;
        end else if (!res_push && i_res_pop) begin
            n_res_count = r_res_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wptr  <= 1'b0;
            r_res_rptr  <= 1'b0;
            r_res_count <= 2'd0;
        end else begin
            if (res_push) begin
                r_res_wptr <= ~r_res_wptr;
            end
            if (i_res_pop) begin
                r_res_rptr <= ~r_res_rptr;
            end
            r_res_count <= n_res_count;
        end
    end

endmodule

// File: rtl/core/point_pair_text_parser.sv
// Text parser for lines of two 3D points. Push one ASCII byte per transaction;
// each line holds six unsigned decimal numbers split by ':' or ' ', and a
// newline yields one result (both points and a pair number that starts at 0
// and wraps). A '-' drops the rest of its line, newline included, and no
// result comes from it. Values saturate at all ones; digits past the sixth
// field and other characters are ignored. One byte is taken per clock while
// full is low. The classifier decodes a byte in the cycle it is accepted and
// writes it to a two-entry token queue; the executor takes one token per
// clock unless none waits or a newline meets a full result queue. The
// two-entry result queue absorbs short pop stalls; longer ones hold a
// newline in the token queue, which then fills and raises full.
module point_pair_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_first_x,
    output logic [15:0] o_first_y,
    output logic [15:0] o_first_z,
    output logic [15:0] o_second_x,
    output logic [15:0] o_second_y,
    output logic [15:0] o_second_z,
    output logic [15:0] o_pair_number
);

    logic             in_accept;
    logic             tok_valid;
    ppt_pkg::t_token  front_token;
    logic             tok_empty;
    logic             tok_pop;
    ppt_pkg::t_token  queue_token;
    logic             res_empty;
    ppt_pkg::t_result result;

    assign in_accept = push && !full;

    // Classify incoming bytes
    ppt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_text_byte (i_text_byte),
        .o_tok_valid (tok_valid),
        .o_token     (front_token)
    );

    // Decouple classifier from executor
    ppt_tok_queue u_tok_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (tok_valid),
        .i_wr_token (front_token),
        .o_full     (full),
        .i_rd_en    (tok_pop),
        .o_empty    (tok_empty),
        .o_rd_token (queue_token)
    );

    // Accumulate fields and emit results
    ppt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_empty (tok_empty),
        .i_token     (queue_token),
        .o_tok_pop   (tok_pop),
        .i_res_pop   (pop && !res_empty),
        .o_res_empty (res_empty),
        .o_result    (result)
    );

    assign empty         = res_empty;
    assign o_first_x     = result.first_x;
    assign o_first_y     = result.first_y;
    assign o_first_z     = result.first_z;
    assign o_second_x    = result.second_x;
    assign o_second_y    = result.second_y;
    assign o_second_z    = result.second_z;
    assign o_pair_number = result.pair_number;

endmodule
